// File: rtl/core/b64lw_pkg.sv
// Package: shared types, character constants and the symbol lookup for the base64 encoder.
`default_nettype none

package b64lw_pkg;

    // ASCII codes used beside the base64 alphabet
    localparam logic [6:0] CHAR_PAD = 7'h3D;  // '='
    localparam logic [6:0] CHAR_CR  = 7'h0D;
    localparam logic [6:0] CHAR_LF  = 7'h0A;

    // Position of the next byte inside its three-byte group
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       last_char;
    } t_out_item;

    // One accepted byte, already turned into its characters
    typedef struct packed {
        logic [1:0]      last_idx;  // index of the final character of the item
        logic [3:0][6:0] chars;
    } t_group_entry;

    // Standard alphabet: A-Z a-z 0-9 + /
    function automatic logic [6:0] sym_char(input logic [5:0] v);
        logic [6:0] c;
        case (v) inside
            [6'd0:6'd25]:  c = 7'h41 + {1'b0, v};
            [6'd26:6'd51]: c = 7'h61 + {1'b0, v} - 7'd26;
            [6'd52:6'd61]: c = 7'h30 + {1'b0, v} - 7'd52;
            6'd62:         c = 7'h2B;
            default:       c = 7'h2F;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/b64lw_front.sv
// Front end: accepts bytes, tracks group and line state, builds each item's characters.
`default_nettype none

module b64lw_front
    import b64lw_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    output logic              o_full,
    input  wire t_in_item     i_in_item,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_wrap_length,
    output logic              o_q_push,
    output t_group_entry      o_q_entry,
    input  wire logic         i_q_full
);

    logic [1:0] r_pos,  n_pos;
    logic [3:0] r_left, n_left;
    logic [7:0] r_rem,  n_rem;
    logic [7:0] r_wrap;

    // Reduction of the line count modulo a new wrap length, one bit a cycle
    logic       r_red_busy;
    logic [2:0] r_red_cnt;
    logic [7:0] r_red_acc;
    logic [7:0] r_red_src;
    logic [8:0] red_shift;
    logic [8:0] red_next;

    logic       accept;
    logic       cfg_wr;
    logic       wrap_on;
    logic [8:0] line_sum;
    logic [7:0] b;
    logic       fin;

    assign b           = i_in_item.data_byte;
    assign fin         = i_in_item.final_byte;
    assign wrap_on     = (r_wrap != 8'd0);
    assign o_cfg_ready = !r_red_busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_full      = i_q_full || r_red_busy;
    assign accept      = i_push && !o_full;
    assign o_q_push    = accept;

    // Count stays below the wrap length, so a few subtractions finish the modulo
    always_comb begin
        line_sum = {1'b0, r_rem} + 9'd4;
        for (int i = 0; i < 4; i++) begin
            if (line_sum >= {1'b0, r_wrap}) begin
                line_sum = line_sum - {1'b0, r_wrap};
            end
        end
    end

    always_comb begin
        red_shift = {r_red_acc, r_red_src[7]};
        red_next  = (red_shift >= {1'b0, r_wrap}) ? red_shift - {1'b0, r_wrap} : red_shift;
    end

    always_comb begin
        n_pos  = r_pos;
        n_left = r_left;
        n_rem  = r_rem;
        o_q_entry = '0;
        case (r_pos)
            POS_SECOND: begin
                o_q_entry.chars[0] = sym_char({r_left[1:0], b[7:4]});
                n_left = b[3:0];
                n_pos  = POS_THIRD;
                if (fin) begin
                    o_q_entry.chars[1] = sym_char({b[3:0], 2'b00});
                    o_q_entry.chars[2] = CHAR_PAD;
                    o_q_entry.last_idx = 2'd2;
                end
            end
            POS_THIRD: begin
                o_q_entry.chars[0] = sym_char({r_left, b[7:6]});
                o_q_entry.chars[1] = sym_char(b[5:0]);
                o_q_entry.last_idx = 2'd1;
                n_left = 4'd0;
                n_pos  = POS_FIRST;
                if (wrap_on) begin
                    n_rem = line_sum[7:0];
                    if (line_sum[7:0] == 8'd0) begin
                        o_q_entry.chars[2] = CHAR_CR;
                        o_q_entry.chars[3] = CHAR_LF;
                        o_q_entry.last_idx = 2'd3;
                    end
                end
            end
            default: begin
                o_q_entry.chars[0] = sym_char(b[7:2]);
                n_left = {2'b00, b[1:0]};
                n_pos  = POS_SECOND;
                if (fin) begin
                    o_q_entry.chars[1] = sym_char({b[1:0], 4'b0000});
                    o_q_entry.chars[2] = CHAR_PAD;
                    o_q_entry.chars[3] = CHAR_PAD;
                    o_q_entry.last_idx = 2'd3;
                end
            end
        endcase
        if (fin) begin
            n_pos  = POS_FIRST;
            n_left = 4'd0;
            n_rem  = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_FIRST;
            r_left     <= 4'd0;
            r_rem      <= 8'd0;
            r_wrap     <= 8'd0;
            r_red_busy <= 1'b0;
            r_red_cnt  <= 3'd0;
        end else begin
            if (accept) begin
                r_pos  <= n_pos;
                r_left <= n_left;
                r_rem  <= n_rem;
            end
            if (cfg_wr) begin
                r_wrap     <= i_cfg_wrap_length;
                r_red_busy <= (i_cfg_wrap_length != 8'd0);
                r_red_cnt  <= 3'd0;
            end else if (r_red_busy) begin
                r_red_cnt <= r_red_cnt + 3'd1;
                if (r_red_cnt == 3'd7) begin
                    r_red_busy <= 1'b0;
                    r_rem      <= red_next[7:0];
                end
            end
        end
    end

    // Datapath of the reduction needs no reset
    always_ff @(posedge i_clk) begin
        if (cfg_wr) begin
            r_red_acc <= 8'd0;
            r_red_src <= r_rem;
        end else if (r_red_busy) begin
            r_red_acc <= red_next[7:0];
            r_red_src <= {r_red_src[6:0], 1'b0};
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/b64lw_queue.sv
// Small register queue of encoded items between front and back end.
`default_nettype none

module b64lw_queue
    import b64lw_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_group_entry  i_entry,
    output logic               o_full,
    input  wire logic          i_pop,
    output t_group_entry       o_entry,
    output logic               o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_group_entry     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr;
    logic             rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (wr && !rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (rd && !wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/b64lw_back.sv
// Back end: moves queued items into the output register one character a cycle while not stalled.
`default_nettype none

module b64lw_back
    import b64lw_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_group_entry  i_q_entry,
    input  wire logic          i_q_empty,
    output logic               o_q_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output t_out_item          o_out_item
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       slot_free;
    logic       take;
    logic       at_last;

    assign slot_free  = !r_out_valid || i_pop;
    assign take       = slot_free && !i_q_empty;
    assign at_last    = (r_idx == i_q_entry.last_idx);
    assign o_q_pop    = take && at_last;
    assign o_empty    = !r_out_valid;
    assign o_out_item = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
                r_idx       <= at_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out.out_char  <= i_q_entry.chars[r_idx];
            r_out.last_char <= at_last;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/base64_encoder_line_wrap.sv
// Top level of the base64 encoder with CR LF line wrap.
// A byte taken is stored in the item queue; its first character then goes to the output register.
// Throughput: up to one byte a cycle into the item queue while full is low; the output
//   gives one character a cycle while popped; a byte gives 1 to 4 (4/3 on average plus CR LF).
// Reset (synchronous, active low) clears group state, line count, wrap length and queue.
// A wrap length write of a nonzero value raises full while the count reduces.
`default_nettype none

module base64_encoder_line_wrap
    import b64lw_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input, queue style
    input  wire logic        push,
    output logic             full,
    input  wire t_in_item    i_in_item,
    // character output, queue style
    output logic             empty,
    input  wire logic        pop,
    output t_out_item        o_out_item,
    // wrap length register
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  i_cfg_wrap_length
);

    // Encoded items pass from the front end to the back end through this queue.
    // Each entry carries up to four characters and the index of the last one.
    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_empty;
    t_group_entry q_wr_entry;
    t_group_entry q_rd_entry;

    // Front end: take a byte whenever the queue has room and no reduction runs, update group
    // position, leftover bits and line count, and emit the whole item's characters at once.
    b64lw_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_in_item         (i_in_item),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_wrap_length (i_cfg_wrap_length),
        .o_q_push          (q_push),
        .o_q_entry         (q_wr_entry),
        .i_q_full          (q_full)
    );

    // Decouple the two sides so a stalled consumer does not block byte intake
    // until the queue fills.
    b64lw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_entry (q_rd_entry),
        .o_empty (q_empty)
    );

    // Back end: while the output is free, hand out one character per cycle from
    // the queue head, flag the item's last one and drop the entry once it has left.
    b64lw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_entry  (q_rd_entry),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire

// File: rtl/core/b64lw_checker.sv
// Port-level checker for the base64 encoder, bound to the top level.
`default_nettype none

module b64lw_checker
    import b64lw_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire t_out_item   o_out_item,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [7:0]  i_cfg_wrap_length
);

    // No character may be offered right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("output not empty after reset");

    // A stalled character holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_item))
        else $error("output changed while stalled");

    // A line break always closes an item, and CR never does
    a_lf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out_item.out_char == CHAR_LF |-> o_out_item.last_char)
        else $error("LF not flagged as last character");

    a_cr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out_item.out_char == CHAR_CR |-> !o_out_item.last_char)
        else $error("CR flagged as last character");

    // Input is held off while the line count is reduced for a new wrap length
    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && cfg_valid && cfg_ready && i_cfg_wrap_length != 8'd0 |=> full && !cfg_ready)
        else $error("input not stalled after wrap length write");

endmodule

bind base64_encoder_line_wrap b64lw_checker u_b64lw_checker (.*);

`default_nettype wire
